// File: design/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define PDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define PDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pdc_pkg.sv
`default_nettype none

package pdc_pkg;

    // Request codes of the input word.
    localparam logic [1:0] REQ_KEY_CHAR = 2'd0;
    localparam logic [1:0] REQ_KEY_DONE = 2'd1;
    localparam logic [1:0] REQ_TEXT     = 2'd2;

    // Letter indexes (A is zero).
    localparam logic [4:0] LETTER_I    = 5'd8;
    localparam logic [4:0] LETTER_J    = 5'd9;
    localparam logic [4:0] LETTER_X    = 5'd23;
    localparam logic [4:0] LETTER_LAST = 5'd25;

    localparam int ALPHA = 26;
    localparam int CELLS = 25;

    localparam logic [4:0] CELLS_USED = 5'd25;
    localparam logic [2:0] SIDE_LAST  = 3'd4;
    localparam logic [6:0] ASCII_A    = 7'd65;

    localparam logic [25:0] PLACED_RESET = 26'd1 << LETTER_J;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOOK_A,
        ST_LOOK_B,
        ST_GRID_1,
        ST_GRID_2,
        ST_EMIT_2
    } state_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } letter_t;

    // Upper-cases an ASCII byte and returns its letter index.
    function automatic letter_t letter_of(input logic [7:0] code);
        letter_t res;
        res.ok  = 1'b0;
        res.idx = 5'd0;
        if (code inside {[8'd97:8'd122]})
        begin
            res.ok  = 1'b1;
            res.idx = 5'(code - 8'd97);
        end
        else if (code inside {[8'd65:8'd90]})
        begin
            res.ok  = 1'b1;
            res.idx = 5'(code - 8'd65);
        end
        return res;
    endfunction

    // Row of a table position 0..24.
    function automatic logic [2:0] pos_row(input logic [4:0] pos);
        logic [2:0] row;
        if (pos >= 5'd20)
            row = 3'd4;
        else if (pos >= 5'd15)
            row = 3'd3;
        else if (pos >= 5'd10)
            row = 3'd2;
        else if (pos >= 5'd5)
            row = 3'd1;
        else
            row = 3'd0;
        return row;
    endfunction

    // Table position of a row and column.
    function automatic logic [4:0] pos_of(input logic [2:0] row, input logic [2:0] col);
        logic [4:0] r5;
        r5 = {2'b00, row};
        return 5'((r5 << 2) + r5 + {2'b00, col});
    endfunction

    // Column of a table position 0..24.
    function automatic logic [2:0] pos_col(input logic [4:0] pos);
        logic [4:0] base;
        base = pos_of(pos_row(pos), 3'd0);
        return 3'(pos - base);
    endfunction

    // One step right or down (enc) or left or up, wrapping around the side.
    function automatic logic [2:0] side_step(input logic [2:0] v, input logic enc);
        logic [2:0] res;
        if (enc)
            res = (v == SIDE_LAST) ? 3'd0 : 3'(v + 3'd1);
        else
            res = (v == 3'd0) ? SIDE_LAST : 3'(v - 3'd1);
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/pdc_ifs.sv
`default_nettype none

// Request channel: one word per key character, key complete or text character.
interface pdc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output req_type, output char_code, output end_of_text,
                    input ready);
    modport sink   (input valid, input req_type, input char_code, input end_of_text,
                    output ready);
endinterface

// Result channel: one word per output letter.
interface pdc_res_if;
    logic       valid;
    logic       ready;
    logic [6:0] cipher_letter;
    logic       second_of_pair;
    logic       message_end;

    modport source (output valid, output cipher_letter, output second_of_pair,
                    output message_end, input ready);
    modport sink   (input valid, input cipher_letter, input second_of_pair,
                    input message_end, output ready);
endinterface

// Configuration write channel for the mode register.
interface pdc_cfg_if;
    logic valid;
    logic ready;
    logic encrypt_mode;

    modport source (output valid, output encrypt_mode, input ready);
    modport sink   (input valid, input encrypt_mode, output ready);
endinterface

`default_nettype wire

// File: design/pdc_ram.sv
`default_nettype none

module pdc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/pdc_rule.sv
`default_nettype none

// Applies the row, column or rectangle rule to two table positions and
// returns the two positions to read back.
module pdc_rule
    import pdc_pkg::*;
(
    input  wire logic       enc,
    input  wire logic [4:0] pos_a,
    input  wire logic [4:0] pos_b,
    output logic      [4:0] out_a,
    output logic      [4:0] out_b
);

    logic [2:0] r1, c1, r2, c2;

    always_comb
    begin
        r1 = pos_row(pos_a);
        c1 = pos_col(pos_a);
        r2 = pos_row(pos_b);
        c2 = pos_col(pos_b);
        if (r1 == r2)
        begin
            out_a = pos_of(r1, side_step(c1, enc));
            out_b = pos_of(r2, side_step(c2, enc));
        end
        else if (c1 == c2)
        begin
            out_a = pos_of(side_step(r1, enc), c1);
            out_b = pos_of(side_step(r2, enc), c2);
        end
        else
        begin
            out_a = pos_of(r1, c2);
            out_b = pos_of(r2, c1);
        end
    end

endmodule

`default_nettype wire

// File: design/playfair_digraph_cipher_unit.sv
`default_nettype none
// A key character is placed when it is accepted; key complete walks all 26 letters in ST_FILL.
// A text character that completes a pair walks ST_LOOK_A, ST_LOOK_B and ST_GRID_1;
// ST_GRID_2 shows its first letter and ST_EMIT_2 the second, then the block is ready.
// It takes no new word meanwhile, as the single read port of each table RAM is reused.
// Reset: rst_n is asynchronous, active low; it places J only, empties the table and
// pending letter, drops any result word and sets encrypt_mode to 1.

module playfair_digraph_cipher_unit
    import pdc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pdc_cfg_if.sink   cfg,
    pdc_req_if.sink   req,
    pdc_res_if.source res
);

    // The table lives in two small RAMs: grid maps a position to its letter,
    // and the position RAM maps a letter back to where it sits.  The same read
    // port of each RAM is reused for both letters of a pair, so a pair walks
    // through a short sequence of read states.

    state_t state_reg, state_next;

    logic        enc_reg;
    logic [25:0] placed_reg;
    logic [4:0]  fill_reg;
    logic [4:0]  idx_reg;
    logic [4:0]  held_letter_reg;
    logic        held_valid_reg;
    logic [4:0]  pa_reg;
    logic [4:0]  pb_reg;
    logic        last_reg;
    logic [4:0]  ca_reg;
    logic [4:0]  addr2_reg;

    logic        out_valid_reg;
    logic [6:0]  out_letter_reg;
    logic        out_second_reg;
    logic        out_end_reg;

    logic        accept;
    letter_t     lt;
    logic        slot_free;

    logic        place_en;
    logic [4:0]  place_letter;
    logic        place_do;

    logic        pair_go;
    logic [4:0]  pair_a;
    logic [4:0]  pair_b;
    logic        pair_last;
    logic [4:0]  pair_b_eq;
    logic        held_clear;
    logic        held_set;

    logic        pos_re;
    logic [4:0]  pos_raddr;
    logic [4:0]  pos_rdata;
    logic        grid_re;
    logic [4:0]  grid_raddr;
    logic [4:0]  grid_rdata;
    logic [4:0]  rule_a;
    logic [4:0]  rule_b;

    logic        out_load;
    logic        out_second;
    logic        out_end;

    assign accept    = req.valid && req.ready;
    assign lt        = letter_of(req.char_code);
    assign slot_free = !out_valid_reg || res.ready;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign res.valid          = out_valid_reg;
    assign res.cipher_letter  = out_letter_reg;
    assign res.second_of_pair = out_second_reg;
    assign res.message_end    = out_end_reg;

    // A letter is placed only once, and never once the table holds 25 letters.
    assign place_do = place_en && !placed_reg[place_letter] && (fill_reg < CELLS_USED);

    // Equal letters in a pair turn the second into X; J is looked up as I.
    assign pair_b_eq = (pair_a == pair_b) ? LETTER_X : pair_b;

    pdc_ram #(
        .WIDTH (5),
        .DEPTH (ALPHA)
    ) u_pos_ram (
        .clk   (clk),
        .we    (place_do),
        .waddr (place_letter),
        .wdata (fill_reg),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    pdc_ram #(
        .WIDTH (5),
        .DEPTH (CELLS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (place_do),
        .waddr (fill_reg),
        .wdata (place_letter),
        .re    (grid_re),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    pdc_rule u_rule (
        .enc   (enc_reg),
        .pos_a (ca_reg),
        .pos_b (pos_rdata),
        .out_a (rule_a),
        .out_b (rule_b)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.req_type == REQ_KEY_DONE)
                    state_next = ST_FILL;
                else if (accept && pair_go)
                    state_next = ST_LOOK_A;
            end
            ST_FILL:
            begin
                if (idx_reg == LETTER_LAST)
                    state_next = ST_IDLE;
            end
            ST_LOOK_A: state_next = ST_LOOK_B;
            ST_LOOK_B: state_next = ST_GRID_1;
            ST_GRID_1: state_next = ST_GRID_2;
            ST_GRID_2:
            begin
                if (slot_free)
                    state_next = ST_EMIT_2;
            end
            ST_EMIT_2:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Text pairing: decide whether this word completes a pair, and what
    // happens to the pending letter.
    always_comb
    begin
        pair_go    = 1'b0;
        pair_a     = held_letter_reg;
        pair_b     = LETTER_X;
        pair_last  = 1'b0;
        held_clear = 1'b0;
        held_set   = 1'b0;
        if (state_reg == ST_IDLE && req.req_type == REQ_TEXT)
        begin
            if (!lt.ok)
            begin
                if (req.end_of_text)
                begin
                    held_clear = 1'b1;
                    pair_go    = held_valid_reg;
                    pair_last  = 1'b1;
                end
            end
            else if (held_valid_reg)
            begin
                pair_go    = 1'b1;
                pair_b     = lt.idx;
                pair_last  = req.end_of_text;
                held_clear = 1'b1;
            end
            else if (req.end_of_text)
            begin
                pair_go   = 1'b1;
                pair_a    = lt.idx;
                pair_last = 1'b1;
            end
            else
            begin
                held_set = 1'b1;
            end
        end
    end

    // Memory control and result loading.
    always_comb
    begin
        place_en     = 1'b0;
        place_letter = idx_reg;
        pos_re       = 1'b0;
        pos_raddr    = pa_reg;
        grid_re      = 1'b0;
        grid_raddr   = addr2_reg;
        out_load     = 1'b0;
        out_second   = 1'b0;
        out_end      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                place_letter = lt.idx;
                place_en     = accept && req.req_type == REQ_KEY_CHAR && lt.ok;
            end
            ST_FILL:
            begin
                place_en = 1'b1;
            end
            ST_LOOK_A:
            begin
                pos_re = 1'b1;
            end
            ST_LOOK_B:
            begin
                pos_re    = 1'b1;
                pos_raddr = pb_reg;
            end
            ST_GRID_1:
            begin
                grid_re    = 1'b1;
                grid_raddr = rule_a;
            end
            ST_GRID_2:
            begin
                // The first letter is shown while the second is read.
                out_load = slot_free;
                grid_re  = slot_free;
            end
            ST_EMIT_2:
            begin
                out_load   = slot_free;
                out_second = 1'b1;
                out_end    = last_reg;
            end
            default:
            begin
                place_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            enc_reg         <= 1'b1;
            placed_reg      <= PLACED_RESET;
            fill_reg        <= 5'd0;
            idx_reg         <= 5'd0;
            held_letter_reg <= 5'd0;
            held_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
                enc_reg <= cfg.encrypt_mode;

            if (place_do)
            begin
                placed_reg[place_letter] <= 1'b1;
                fill_reg                 <= 5'(fill_reg + 5'd1);
            end

            if (state_reg == ST_FILL)
                idx_reg <= 5'(idx_reg + 5'd1);
            else
                idx_reg <= 5'd0;

            // Key complete drops any pending text letter.
            if (accept && req.req_type == REQ_KEY_DONE)
            begin
                held_valid_reg  <= 1'b0;
                held_letter_reg <= 5'd0;
            end
            else if (accept && held_clear)
            begin
                held_valid_reg  <= 1'b0;
                held_letter_reg <= 5'd0;
            end
            else if (accept && held_set)
            begin
                held_valid_reg  <= 1'b1;
                held_letter_reg <= lt.idx;
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept && pair_go)
        begin
            pa_reg   <= (pair_a == LETTER_J) ? LETTER_I : pair_a;
            pb_reg   <= (pair_b_eq == LETTER_J) ? LETTER_I : pair_b_eq;
            last_reg <= pair_last;
        end
        if (state_reg == ST_LOOK_B)
            ca_reg <= pos_rdata;
        if (state_reg == ST_GRID_1)
            addr2_reg <= rule_b;
        if (out_load)
        begin
            out_letter_reg <= 7'(ASCII_A + {2'b00, grid_rdata});
            out_second_reg <= out_second;
            out_end_reg    <= out_end;
        end
    end

endmodule

`default_nettype wire

// File: design/pdc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module pdc_checker
    import pdc_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic [1:0] req_type,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [6:0] res_letter,
    input wire logic       res_second,
    input wire logic       res_end
);

    // A stalled result word keeps its contents.
    `PDC_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_letter) && $stable(res_second) && $stable(res_end), "result word changed while stalled")

    // The end of a message is always marked on the second letter of a pair.
    `PDC_ASSERT_IMPL(a_end_on_second, clk, rst_n, res_valid && res_end, res_second, "message end on first letter")

    // Once a first letter is taken, the second letter is presented next.
    `PDC_ASSERT_NEXT(a_pair_follows, clk, rst_n, res_valid && res_ready && !res_second, res_valid && res_second, "second letter of pair did not follow")

    // The key-complete walk keeps the request side busy.
    `PDC_ASSERT_NEXT(a_fill_busy, clk, rst_n, req_valid && req_ready && req_type == REQ_KEY_DONE, !req_ready, "ready during key fill")

    // A key character is placed without stalling the request side.
    `PDC_ASSERT_NEXT(a_key_char_quick, clk, rst_n, req_valid && req_ready && req_type == REQ_KEY_CHAR, req_ready, "key character stalled the request side")

endmodule

bind playfair_digraph_cipher_unit pdc_checker u_pdc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_type   (req.req_type),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_letter (res.cipher_letter),
    .res_second (res.second_of_pair),
    .res_end    (res.message_end)
);

`default_nettype wire
